/* hw/rtl/enbf_pkg.sv */
// ----------------------------------------------------------------------------
// enbf_pkg
// Shared types and constants of the edge normalized box filter.
// ----------------------------------------------------------------------------
package enbf_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_BITS    = 16;
  localparam int CFG_BITS       = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(9);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_in_row;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mean_value;
    logic                   last_of_run;
    logic                   row_done;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DROP_MAIN,
    S_PUSH,
    S_AFTER,
    S_DIV_MAIN,
    S_TAIL,
    S_DROP_TAIL,
    S_DIV_TAIL
  } state_t;

  typedef struct packed {
    logic capture;
    logic drop;
    logic push;
    logic tail_init;
    logic div_start;
    logic load_out;
    logic out_final;
    logic out_row_end;
    logic k_dec;
    logic clear_row;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_ge_w;
    logic emit_main;
    logic tail_zero;
    logic k_zero;
    logic k_one;
    logic cnt_gt_want;
    logic div_busy;
  } stat_t;

endpackage

/* hw/rtl/edge_normalized_box_filter_1d_top.sv */
// ----------------------------------------------------------------------------
// edge_normalized_box_filter_1d_top
// Row-wise moving average whose window shrinks at both row edges.
// ----------------------------------------------------------------------------
// Samples of a row enter on the in channel (valid/stall), the final one with
// last_in_row set. Means leave on the out channel (valid/stall), each the
// rounded sum/count over the clipped window; last_of_run marks the final
// result of an input request and row_done the final result of the row.
// cfg_we/cfg_data write the window length and abandon any row in progress.
// One request at a time: no new request is taken until the last one and all
// of its means, each computed by the bit-serial divider, are loaded. The next
// request is taken while a finished mean still waits in the output register.
// A stalled receiver holds the output register and the controller waits
// before loading the next mean. Synchronous reset empties the row, drops
// any pending result and sets the window length to 9.
// ----------------------------------------------------------------------------
module edge_normalized_box_filter_1d_top #(
  parameter int MAX_WINDOW = enbf_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  enbf_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output enbf_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [enbf_pkg::CFG_BITS-1:0] cfg_data
);

  import enbf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  enbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  enbf_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/enbf_ram.sv */
// ----------------------------------------------------------------------------
// enbf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module enbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/enbf_div.sv */
// ----------------------------------------------------------------------------
// enbf_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module enbf_div #(
  parameter int QUO_BITS = 16,
  parameter int DEN_BITS = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [QUO_BITS+DEN_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0]          denom,
  output logic                         busy,
  output logic [QUO_BITS-1:0]          quot
);

  localparam int SW = $clog2(QUO_BITS + 1);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] d;
  logic [QUO_BITS-1:0] q;
  logic [SW-1:0]       step;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // numerator is below denom << QUO_BITS, so the upper part starts below denom
  assign trial = {rem, q[QUO_BITS-1]};
  assign diff  = trial - {1'b0, d};
  assign fits  = trial >= {1'b0, d};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + SW'(1);
      if (step == SW'(QUO_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer[QUO_BITS+DEN_BITS-1:QUO_BITS];
      q   <= numer[QUO_BITS-1:0];
      d   <= denom;
    end else if (busy) begin
      rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      q   <= {q[QUO_BITS-2:0], fits};
    end
  end

endmodule

/* hw/rtl/enbf_dp.sv */
// ----------------------------------------------------------------------------
// enbf_dp
// Datapath: window register, delay line, running sum, counts and divider.
// ----------------------------------------------------------------------------
module enbf_dp #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [enbf_pkg::CFG_BITS-1:0]         cfg_data,
  input  enbf_pkg::in_t                         in_data,
  input  enbf_pkg::cmd_t                        cmd,
  output enbf_pkg::stat_t                       stat,
  output enbf_pkg::out_t                        out_data
);

  import enbf_pkg::*;

  localparam int AW       = $clog2(MAX_WINDOW);
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
  localparam int WCMP     = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

  logic [CFG_BITS-1:0]    win;
  logic [SUM_BITS-1:0]    sum;
  logic [AW-1:0]          wp;
  logic [CNT_BITS-1:0]    seen;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    k;
  logic [SAMPLE_BITS-1:0] x;
  logic                   last;

  logic [WCMP-1:0]        win_ext;
  logic [CNT_BITS-1:0]    w;
  logic [CNT_BITS-1:0]    half;
  logic [CNT_BITS-1:0]    tail;
  logic [CNT_BITS-1:0]    want;
  logic [CNT_BITS-1:0]    wp_ext;
  logic [CNT_BITS-1:0]    oldest;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SUM_BITS-1:0]    numer;
  logic [SAMPLE_BITS-1:0] quot;
  logic                   div_busy;

  // effective window: zero acts as one, large values clip to the depth
  assign win_ext = WCMP'(win);
  always_comb begin
    priority if (win == '0) begin
      w = CNT_BITS'(1);
    end else if (win_ext > WCMP'(MAX_WINDOW)) begin
      w = CNT_BITS'(MAX_WINDOW);
    end else begin
      w = CNT_BITS'(win_ext);
    end
  end

  assign half = w >> 1;
  assign tail = (seen < half) ? seen : half;
  assign want = w - half - CNT_BITS'(1) + k;

  // slot of the oldest sample held in the sum
  assign wp_ext = CNT_BITS'(wp);
  assign oldest = (wp_ext >= count) ? (wp_ext - count)
                                    : (wp_ext + CNT_BITS'(MAX_WINDOW) - count);

  enbf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_line (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wp),
    .wdata (x),
    .raddr (oldest[AW-1:0]),
    .rdata (rdata)
  );

  // rounded mean: (sum + count/2) / count
  assign numer = sum + SUM_BITS'(count >> 1);

  enbf_div #(
    .QUO_BITS (SAMPLE_BITS),
    .DEN_BITS (CNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (numer),
    .denom (count),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= WINDOW_RESET;
      sum   <= '0;
      wp    <= '0;
      seen  <= '0;
      count <= '0;
      k     <= '0;
    end else if (cfg_we) begin
      win   <= cfg_data;
      sum   <= '0;
      wp    <= '0;
      seen  <= '0;
      count <= '0;
    end else begin
      if (cmd.clear_row) begin
        sum   <= '0;
        wp    <= '0;
        seen  <= '0;
        count <= '0;
      end else if (cmd.drop) begin
        sum   <= sum - SUM_BITS'(rdata);
        count <= count - CNT_BITS'(1);
      end else if (cmd.push) begin
        sum   <= sum + SUM_BITS'(x);
        count <= count + CNT_BITS'(1);
        wp    <= (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + AW'(1);
        if (seen < w) begin
          seen <= seen + CNT_BITS'(1);
        end
      end
      if (cmd.tail_init) begin
        k <= tail;
      end else if (cmd.k_dec) begin
        k <= k - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x    <= in_data.sample;
      last <= in_data.last_in_row;
    end
    if (cmd.load_out) begin
      out_data.mean_value  <= quot;
      out_data.last_of_run <= cmd.out_final;
      out_data.row_done    <= cmd.out_row_end;
    end
  end

  always_comb begin
    stat.last        = last;
    stat.cnt_ge_w    = count >= w;
    stat.emit_main   = seen > half;
    stat.tail_zero   = tail == '0;
    stat.k_zero      = k == '0;
    stat.k_one       = k == CNT_BITS'(1);
    stat.cnt_gt_want = count > want;
    stat.div_busy    = div_busy;
  end

endmodule

/* hw/rtl/enbf_ctrl.sv */
// ----------------------------------------------------------------------------
// enbf_ctrl
// Controller: sequences window update, mean division, tail flush and output.
// ----------------------------------------------------------------------------
module enbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  enbf_pkg::stat_t stat,
  output enbf_pkg::cmd_t  cmd
);

  import enbf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = stat.cnt_ge_w ? S_DROP_MAIN : S_PUSH;
      end
      S_DROP_MAIN: state_next = S_PUSH;
      S_PUSH:      state_next = S_AFTER;
      S_AFTER: begin
        priority if (stat.emit_main) state_next = S_DIV_MAIN;
        else if (stat.last)          state_next = S_TAIL;
        else                         state_next = S_IDLE;
      end
      S_DIV_MAIN: begin
        if (!stat.div_busy && out_free) begin
          state_next = stat.last ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        priority if (stat.k_zero) state_next = S_IDLE;
        else if (stat.cnt_gt_want) state_next = S_DROP_TAIL;
        else                       state_next = S_DIV_TAIL;
      end
      S_DROP_TAIL: state_next = S_TAIL;
      S_DIV_TAIL: begin
        if (!stat.div_busy && out_free) state_next = S_TAIL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:      cmd.capture = in_valid;
      S_CHECK:     ;
      S_DROP_MAIN: cmd.drop = 1'b1;
      S_PUSH:      cmd.push = 1'b1;
      S_AFTER: begin
        cmd.div_start = stat.emit_main;
        cmd.tail_init = !stat.emit_main && stat.last;
      end
      S_DIV_MAIN: begin
        if (!stat.div_busy && out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_final   = !stat.last || stat.tail_zero;
          cmd.out_row_end = stat.last && stat.tail_zero;
          cmd.tail_init   = stat.last;
        end
      end
      S_TAIL: begin
        cmd.clear_row = stat.k_zero;
        cmd.div_start = !stat.k_zero && !stat.cnt_gt_want;
      end
      S_DROP_TAIL: cmd.drop = 1'b1;
      S_DIV_TAIL: begin
        if (!stat.div_busy && out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_final   = stat.k_one;
          cmd.out_row_end = stat.k_one;
          cmd.k_dec       = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge normalized box filter. Rows of samples are
// sent under several window lengths, each accepted request is run through an
// in-bench model of the clipped moving average, and every mean that leaves
// the block is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import enbf_pkg::*;

  localparam int          CLK_HALF    = 10;
  localparam int          RESET_LEN   = 6;
  localparam int          SETTLE_GAP  = 40;
  localparam int          END_GAP     = 64;
  localparam longint      CYCLE_LIMIT = 2000000;
  localparam int          LINE_DEPTH  = MAX_WINDOW_DEF;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count     = 0;
  longint      cycle_cnt     = 0;

  // model of the filter state
  logic [SAMPLE_BITS-1:0] row_samples [LINE_DEPTH];
  logic [21:0]            row_sum     = '0;
  logic [5:0]             row_wr_ptr  = '0;
  int unsigned            row_inputs  = 0;
  int unsigned            sum_count   = 0;
  logic [CFG_BITS-1:0]    window_reg  = WINDOW_RESET;

  out_t expected_means [$];

  edge_normalized_box_filter_1d_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned eff_window();
    int unsigned w;
    w = window_reg;
    if (w == 0) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic void clear_row();
    row_sum    = '0;
    row_wr_ptr = '0;
    row_inputs = 0;
    sum_count  = 0;
  endfunction

  function automatic void drop_oldest_sample();
    int unsigned pos;
    if (sum_count == 0) return;
    pos = (int'(row_wr_ptr) + LINE_DEPTH - sum_count) % LINE_DEPTH;
    row_sum   = row_sum - row_samples[pos];
    sum_count = sum_count - 1;
  endfunction

  function automatic out_t take_mean();
    longint unsigned q;
    out_t            r;
    if (sum_count == 0) q = 0;
    else q = (longint'(row_sum) + sum_count / 2) / sum_count;
    r.mean_value  = q[SAMPLE_BITS-1:0];
    r.last_of_run = 1'b0;
    r.row_done    = 1'b0;
    return r;
  endfunction

  // works out every mean that one accepted request gives
  task automatic predict_means(input logic [SAMPLE_BITS-1:0] smp, input logic lst);
    int unsigned w, h, tail, want, k;
    out_t        run_q [$];
    w = eff_window();
    h = (w + 2) / 2;
    if (sum_count >= w) drop_oldest_sample();
    row_samples[row_wr_ptr] = smp;
    row_wr_ptr = row_wr_ptr + 6'd1;
    row_sum    = row_sum + smp;
    sum_count  = sum_count + 1;
    if (row_inputs < w) row_inputs = row_inputs + 1;
    if (row_inputs >= h) run_q.push_back(take_mean());
    if (lst) begin
      tail = (row_inputs < h - 1) ? row_inputs : h - 1;
      for (k = tail; k > 0; k--) begin
        // window shrinks toward the right edge of the row
        want = w - h + k;
        while (sum_count > want) drop_oldest_sample();
        run_q.push_back(take_mean());
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].row_done = 1'b1;
      clear_row();
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) expected_means.push_back(run_q[i]);
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: smp, last_in_row: lst};
    do @(posedge clk); while (in_stall);
    predict_means(smp, lst);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    // a request with no mean may still be in flight
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_BITS-1:0] v);
    wait_for_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg = v;
    clear_row();
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_row(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // ---------------------------------------------------------------- checker

  function automatic void report_field(input string name, input longint unsigned exp_v,
                                       input longint unsigned act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        err_count++;
        $display("%0t: unexpected mean, expected none actual %0h/%b/%b", $time,
                 out_data.mean_value, out_data.last_of_run, out_data.row_done);
      end else begin
        exp_r = expected_means.pop_front();
        report_field("mean_value", exp_r.mean_value, out_data.mean_value);
        report_field("last_of_run", exp_r.last_of_run, out_data.last_of_run);
        report_field("row_done", exp_r.row_done, out_data.row_done);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d means outstanding", $time, expected_means.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset window of 9: full-scale samples, a row just reaching the half window,
  // a row shorter than it and a single-sample row
  task automatic test_reset_window_extremes();
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b1);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample('1, 1'b1);
  endtask

  // length zero acts as a one-sample window
  task automatic test_window_zero();
    write_window('0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b1);
    send_sample(16'h007b, 1'b1);
  endtask

  // length above the delay line saturates, so this short row flushes at its end
  task automatic test_window_over_max();
    write_window('1);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b1);
  endtask

  // a window write drops the open row, the next sample starts a fresh one
  task automatic test_row_abandon();
    write_window(CFG_BITS'(2));
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    write_window(CFG_BITS'(3));
    send_sample(16'h8000, 1'b0);
    send_sample('1, 1'b1);
  endtask

  task automatic test_random_rows(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned n_items);
    int unsigned sent, rows, len, r;
    logic [CFG_BITS-1:0] w;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      case ($urandom_range(7))
        0: w = '0;
        1: w = CFG_BITS'(1);
        2: w = CFG_BITS'(2);
        3: w = CFG_BITS'(LINE_DEPTH);
        4: w = CFG_BITS'($urandom_range(65, 127));
        default: w = CFG_BITS'($urandom_range(3, 63));
      endcase
      write_window(w);
      rows = $urandom_range(2, 5);
      for (r = 0; r < rows && sent < n_items; r++) begin
        // mostly short rows, now and then a longer one that can fill the window
        if ($urandom_range(99) < 12) len = $urandom_range(30, 80);
        else len = $urandom_range(1, 12);
        send_row(len);
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window_extremes();
    test_window_zero();
    test_window_over_max();
    test_row_abandon();
    test_random_rows(19, 68, 145);
    test_random_rows(68, 19, 145);
    test_random_rows(0, 0, 145);
    wait_for_idle();
    repeat (END_GAP) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/enbf_pkg.sv
hw/rtl/enbf_ram.sv
hw/rtl/enbf_div.sv
hw/rtl/enbf_dp.sv
hw/rtl/enbf_ctrl.sv
hw/rtl/edge_normalized_box_filter_1d_top.sv
sim/tb_top.sv
